>>> hdl/erct_pkg.sv
// shared constants, mode codes and control struct for the edge removal
// connectivity test; no dependencies
package erct_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 128;

  localparam int VERTEX_W   = 6;
  localparam int EDGE_W     = 7;
  localparam int COUNT_W    = 7;
  localparam int MODE_W     = 2;
  localparam int ENDPOINT_W = 2 * VERTEX_W;
  localparam int EDGE_SPAN  = 1 << EDGE_W;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // adjacency memory commands, at most one per cycle
  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } adj_ctl_t;

endpackage

>>> hdl/edge_removal_connectivity_test.sv
// top level of the edge removal connectivity test: sequencer and stream ports
// depends on erct_pkg, erct_adj_mem, erct_edge_table, erct_row_unit
//
// usage
//   input items arrive on s_tvalid/s_tready; s_tuser carries the mode (clear,
//   add edge, query), s_tdata the edge number and the two endpoints.
//   a query gives one item on m_tvalid/m_tready: the echoed edge number and a
//   flag that is set when some vertex below vertex_count is left unreached with
//   the queried edge removed. clear and add give nothing back.
//   vertex_count is written with vertex_count_we while the block is idle.
// sequence of each item
//   clear: rows are dropped in the accept cycle. add: read-modify-write of
//   both endpoint rows. query: endpoint read, then a flood from the first
//   endpoint; each row is merged in the cycle after it is read. s_tready is
//   low while an add or a query runs.
// reset and stall
//   rst (synchronous) empties the graph through the row valid flags and sets
//   vertex_count to 1. a finished answer sits in the output register; the next
//   item is taken meanwhile, and a later query waits only when it finishes
//   before the receiver has taken the earlier answer.
module edge_removal_connectivity_test #(
  parameter int MAX_VERTICES = erct_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = erct_pkg::DEF_MAX_EDGES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vertex_count_we,
  input  logic [erct_pkg::COUNT_W-1:0] vertex_count,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [6:0] edge_number, [12:7] left_vertex, [18:13] right_vertex, rest zero
  input  logic [23:0]                 s_tdata,
  // [1:0] mode
  input  logic [erct_pkg::MODE_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [6:0] queried_edge, [7] disconnected
  output logic [7:0]                  m_tdata
);
  import erct_pkg::*;

  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_WR_L,
    S_ADD_RD_R,
    S_ADD_WR_R,
    S_Q_INIT,
    S_FLOOD,
    S_DONE
  } state_t;

  state_t state;

  // unpacked input item
  logic [MODE_W-1:0]   in_mode;
  logic [EDGE_W-1:0]   in_edge;
  logic [VERTEX_W-1:0] in_left;
  logic [VERTEX_W-1:0] in_right;
  logic                accept;
  logic                add_ok;

  // working registers
  logic [MAX_VERTICES-1:0] live_mask;
  logic [MAX_VERTICES-1:0] reached;
  logic [MAX_VERTICES-1:0] pending;
  logic                    inflight;
  logic [VA_W-1:0]         rd_vertex;
  logic [VA_W-1:0]         cut_a;
  logic [VA_W-1:0]         cut_b;
  logic [VA_W-1:0]         add_left;
  logic [VA_W-1:0]         add_right;
  logic [EDGE_W-1:0]       q_edge;

  // next values and datapath wiring
  logic [MAX_VERTICES-1:0] pending_next;
  logic [MAX_VERTICES-1:0] reached_next;
  logic [VA_W-1:0]         pick;
  logic [ENDPOINT_W-1:0]   ep_data;
  logic [VERTEX_W-1:0]     ep_left;
  logic [VERTEX_W-1:0]     ep_right;
  logic [VA_W-1:0]         ep_a;
  logic [VA_W-1:0]         ep_b;
  logic                    edge_wr;
  logic                    edge_rd;
  adj_ctl_t                adj_ctl;
  logic [VA_W-1:0]         adj_addr;
  logic [MAX_VERTICES-1:0] rd_row;
  logic [MAX_VERTICES-1:0] set_row;
  logic [MAX_VERTICES-1:0] grown;
  logic [VA_W-1:0]         set_bit;
  logic                    disconnected;
  logic                    out_load;

  // vertices below the clamped count
  function automatic logic [MAX_VERTICES-1:0] live_of(input logic [COUNT_W-1:0] count);
    logic [COUNT_W-1:0]      n;
    logic [MAX_VERTICES-1:0] m;
    n = count;
    if (n < COUNT_W'(1)) begin
      n = COUNT_W'(1);
    end
    if (n > COUNT_W'(MAX_VERTICES)) begin
      n = COUNT_W'(MAX_VERTICES);
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = (COUNT_W'(i) < n);
    end
    return m;
  endfunction

  assign in_mode  = s_tuser;
  assign in_edge  = s_tdata[6:0];
  assign in_left  = s_tdata[12:7];
  assign in_right = s_tdata[18:13];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign add_ok   = (COUNT_W'(in_left) < COUNT_W'(MAX_VERTICES)) &&
                    (COUNT_W'(in_right) < COUNT_W'(MAX_VERTICES));

  // endpoint table: written on an add, read on a query
  assign edge_wr = accept && (in_mode == MODE_ADD) && add_ok;
  assign edge_rd = accept && (in_mode == MODE_QUERY);

  erct_edge_table #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edge_table (
    .clk         (clk),
    .edge_number (in_edge),
    .wr_en       (edge_wr),
    .wr_data     ({in_right, in_left}),
    .rd_en       (edge_rd),
    .rd_data     (ep_data)
  );

  // endpoints out of range fall back to vertex zero
  assign ep_left  = ep_data[VERTEX_W-1:0];
  assign ep_right = ep_data[ENDPOINT_W-1:VERTEX_W];
  assign ep_a = (COUNT_W'(ep_left) < COUNT_W'(MAX_VERTICES)) ? ep_left[VA_W-1:0] : '0;
  assign ep_b = (COUNT_W'(ep_right) < COUNT_W'(MAX_VERTICES)) ? ep_right[VA_W-1:0] : '0;

  // lowest pending vertex is the next row to read
  always_comb begin
    pick = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick = VA_W'(i);
      end
    end
  end

  // adjacency memory commands
  always_comb begin
    adj_ctl  = '0;
    adj_addr = '0;
    case (state)
      S_IDLE: begin
        if (accept && (in_mode == MODE_CLEAR)) begin
          adj_ctl.clear = 1'b1;
        end
        if (edge_wr) begin
          adj_ctl.rd_en = 1'b1;
          adj_addr      = in_left[VA_W-1:0];
        end
      end
      S_ADD_WR_L: begin
        adj_ctl.wr_en = 1'b1;
        adj_addr      = add_left;
      end
      S_ADD_RD_R: begin
        adj_ctl.rd_en = 1'b1;
        adj_addr      = add_right;
      end
      S_ADD_WR_R: begin
        adj_ctl.wr_en = 1'b1;
        adj_addr      = add_right;
      end
      S_FLOOD: begin
        if (pending != '0) begin
          adj_ctl.rd_en = 1'b1;
          adj_addr      = pick;
        end
      end
      default: begin
      end
    endcase
  end

  erct_adj_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .VA_W         (VA_W)
  ) u_adj_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (adj_ctl),
    .addr   (adj_addr),
    .wr_row (set_row),
    .rd_row (rd_row)
  );

  // left row gets the right bit, right row gets the left bit
  assign set_bit = (state == S_ADD_WR_L) ? add_right : add_left;

  erct_row_unit #(
    .MAX_VERTICES (MAX_VERTICES),
    .VA_W         (VA_W)
  ) u_row_unit (
    .row     (rd_row),
    .vertex  (rd_vertex),
    .cut_a   (cut_a),
    .cut_b   (cut_b),
    .set_bit (set_bit),
    .live    (live_mask),
    .reached (reached),
    .set_row (set_row),
    .grown   (grown)
  );

  // flood step: retire the picked vertex, merge the row that came back
  always_comb begin
    pending_next = pending;
    reached_next = reached;
    if (pending != '0) begin
      pending_next = pending_next & ~(ONE << pick);
    end
    if (inflight) begin
      pending_next = pending_next | grown;
      reached_next = reached_next | grown;
    end
  end

  assign disconnected = |(live_mask & ~reached);

  // answer goes into the output register once the earlier one has left
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live_mask <= live_of(COUNT_W'(1));
      reached   <= '0;
      pending   <= '0;
      inflight  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (vertex_count_we) begin
        live_mask <= live_of(vertex_count);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            q_edge    <= in_edge;
            add_left  <= in_left[VA_W-1:0];
            add_right <= in_right[VA_W-1:0];
            if (edge_wr) begin
              state <= S_ADD_WR_L;
            end else if (edge_rd) begin
              state <= S_Q_INIT;
            end
          end
        end
        S_ADD_WR_L: state <= S_ADD_RD_R;
        S_ADD_RD_R: state <= S_ADD_WR_R;
        S_ADD_WR_R: state <= S_IDLE;
        S_Q_INIT: begin
          cut_a    <= ep_a;
          cut_b    <= ep_b;
          reached  <= ONE << ep_a;
          pending  <= ONE << ep_a;
          inflight <= 1'b0;
          state    <= S_FLOOD;
        end
        S_FLOOD: begin
          pending   <= pending_next;
          reached   <= reached_next;
          inflight  <= (pending != '0);
          rd_vertex <= pick;
          if ((pending == '0) && !inflight) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            m_tdata <= {disconnected, q_edge};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/erct_adj_mem.sv
// adjacency row memory with one valid flag per row (invalid rows read as zero)
// depends on erct_pkg
module erct_adj_mem #(
  parameter int MAX_VERTICES = erct_pkg::DEF_MAX_VERTICES,
  parameter int VA_W         = $clog2(MAX_VERTICES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  erct_pkg::adj_ctl_t      ctl,
  input  logic [VA_W-1:0]         addr,
  input  logic [MAX_VERTICES-1:0] wr_row,
  output logic [MAX_VERTICES-1:0] rd_row
);
  import erct_pkg::*;

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] rd_data;
  logic                    rd_valid;

  // valid flags: a clear item drops every row at once
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (ctl.clear) begin
        row_valid <= '0;
      end else if (ctl.wr_en) begin
        row_valid[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid <= row_valid[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_row;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

>>> hdl/erct_edge_table.sv
// endpoint table indexed by edge number reduced to a slot, registered read
// depends on erct_pkg
module erct_edge_table #(
  parameter int MAX_EDGES = erct_pkg::DEF_MAX_EDGES
) (
  input  logic                           clk,
  input  logic [erct_pkg::EDGE_W-1:0]     edge_number,
  input  logic                           wr_en,
  input  logic [erct_pkg::ENDPOINT_W-1:0] wr_data,
  input  logic                           rd_en,
  output logic [erct_pkg::ENDPOINT_W-1:0] rd_data
);
  import erct_pkg::*;

  localparam int SLOT_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [SLOT_W-1:0]     slot_tab [EDGE_SPAN];
  logic [SLOT_W-1:0]     slot;
  logic [ENDPOINT_W-1:0] mem [MAX_EDGES];

  // edge number to slot, worked out at elaboration
  for (genvar g = 0; g < EDGE_SPAN; g++) begin : g_slot
    assign slot_tab[g] = SLOT_W'(g % MAX_EDGES);
  end

  assign slot = slot_tab[edge_number];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[slot];
    end
  end

endmodule

>>> hdl/erct_row_unit.sv
// shared row unit: sets one bit for edge adds, masks and merges rows in the flood
// depends on erct_pkg
module erct_row_unit #(
  parameter int MAX_VERTICES = erct_pkg::DEF_MAX_VERTICES,
  parameter int VA_W         = $clog2(MAX_VERTICES)
) (
  input  logic [MAX_VERTICES-1:0] row,
  input  logic [VA_W-1:0]         vertex,
  input  logic [VA_W-1:0]         cut_a,
  input  logic [VA_W-1:0]         cut_b,
  input  logic [VA_W-1:0]         set_bit,
  input  logic [MAX_VERTICES-1:0] live,
  input  logic [MAX_VERTICES-1:0] reached,
  output logic [MAX_VERTICES-1:0] set_row,
  output logic [MAX_VERTICES-1:0] grown
);
  import erct_pkg::*;

  localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

  logic [MAX_VERTICES-1:0] cut_mask;

  assign set_row = row | (ONE << set_bit);

  // drop the removed edge from either of its end rows
  always_comb begin
    cut_mask = '0;
    if (vertex == cut_a) begin
      cut_mask = cut_mask | (ONE << cut_b);
    end
    if (vertex == cut_b) begin
      cut_mask = cut_mask | (ONE << cut_a);
    end
  end

  assign grown = row & ~cut_mask & live & ~reached;

endmodule
